/* sv/cpcr_pkg.sv */
// ============================================================================
// Circle/plane contact response package
// Shared types, constants and the saturation helper of the contact core.
// ============================================================================
package cpcr_pkg;

    // One in Q16.16.
    localparam int ONE_Q = 65536;

    // In-plane speed above this length counts as sliding.
    localparam int VEL_EPS = 65;

    // In-plane gravity above this length counts as present.
    localparam int GRAV_EPS = 6;

    // Register stages of each part of the pipeline.
    localparam int FRONT_STAGES = 7;
    localparam int SQRT_STEPS   = 32;
    localparam int POST_STAGES  = 3;
    localparam int DIV_STEPS    = 32;

    // Plane and gravity settings.
    typedef struct packed {
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_y;
        logic        [16:0] plane_grip;
        logic        [16:0] plane_bounce;
        logic signed [24:0] gravity_x;
        logic signed [24:0] gravity_y;
    } cfg_t;

    // One incoming circle.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [23:0] radius;
        logic        [20:0] body_mass;
        logic        [16:0] circle_grip;
        logic        [16:0] circle_bounce;
    } item_t;

    // Values that ride alongside the length computations.
    typedef struct packed {
        logic               contact;
        logic signed [31:0] opx;
        logic signed [31:0] opy;
        logic signed [31:0] ovx;
        logic signed [31:0] ovy;
        logic signed [31:0] fnx;
        logic signed [31:0] fny;
        logic signed [31:0] gpx;
        logic signed [31:0] gpy;
        logic signed [31:0] vpx;
        logic signed [31:0] vpy;
        logic        [17:0] grip;
    } side_t;

    // Output of the front pipeline: side values and three squared lengths.
    typedef struct packed {
        side_t       side;
        logic [63:0] fsq;
        logic [63:0] gsq;
        logic [63:0] vsq;
    } front_t;

    // Saturate a wide signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -48'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* sv/cpcr_front.sv */
// ============================================================================
// Contact front pipeline
// Seven register stages: distance and overlap, push-out, gravity split,
// bounce, normal force, in-plane vectors and their squared lengths.
// ============================================================================
module cpcr_front
    import cpcr_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  cfg_t   cfg,
    input  item_t  item,
    output front_t res
);

    // ---------------- stage 1 ----------------
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [50:0] s1_pdx_reg;
    logic signed [50:0] s1_pdy_reg;
    logic signed [45:0] s1_fgx_reg;
    logic signed [45:0] s1_fgy_reg;
    logic signed [49:0] s1_vxn_reg;
    logic signed [49:0] s1_vyn_reg;
    logic        [33:0] s1_up_reg;
    logic        [33:0] s1_ep_reg;
    logic signed [31:0] s1_px_reg;
    logic signed [31:0] s1_py_reg;
    logic signed [31:0] s1_vx_reg;
    logic signed [31:0] s1_vy_reg;
    logic        [23:0] s1_r_reg;

    assign dx = 33'(item.pos_x) - 33'(cfg.plane_x);
    assign dy = 33'(item.pos_y) - 33'(cfg.plane_y);

    // Offset dot normal, weight, normal velocity and factor products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pdx_reg <= dx * 51'(cfg.normal_x);
            s1_pdy_reg <= dy * 51'(cfg.normal_y);
            s1_fgx_reg <= 46'(cfg.gravity_x) * 46'($signed({1'b0, item.body_mass}));
            s1_fgy_reg <= 46'(cfg.gravity_y) * 46'($signed({1'b0, item.body_mass}));
            s1_vxn_reg <= 50'(item.vel_x) * 50'(cfg.normal_x);
            s1_vyn_reg <= 50'(item.vel_y) * 50'(cfg.normal_y);
            s1_up_reg  <= 34'(item.circle_grip) * 34'(cfg.plane_grip);
            s1_ep_reg  <= 34'(item.circle_bounce) * 34'(cfg.plane_bounce);
            s1_px_reg  <= item.pos_x;
            s1_py_reg  <= item.pos_y;
            s1_vx_reg  <= item.vel_x;
            s1_vy_reg  <= item.vel_y;
            s1_r_reg   <= item.radius;
        end
    end

    // ---------------- stage 2 ----------------
    logic signed [51:0] dsum;
    logic signed [35:0] plane_gap;
    logic signed [37:0] ov_next;
    logic signed [50:0] vnsum;
    logic signed [37:0] s2_ov_reg;
    logic               s2_contact_reg;
    logic signed [29:0] s2_fgx_reg;
    logic signed [29:0] s2_fgy_reg;
    logic signed [34:0] s2_vn_reg;
    logic        [17:0] s2_grip_reg;
    logic        [17:0] s2_e_reg;
    logic signed [31:0] s2_px_reg;
    logic signed [31:0] s2_py_reg;
    logic signed [31:0] s2_vx_reg;
    logic signed [31:0] s2_vy_reg;

    assign dsum      = 52'(s1_pdx_reg) + 52'(s1_pdy_reg);
    assign plane_gap = dsum[51:16];
    assign ov_next   = 38'($signed({1'b0, s1_r_reg})) - 38'(plane_gap);
    assign vnsum     = 51'(s1_vxn_reg) + 51'(s1_vyn_reg);

    // Overlap, contact flag and floored Q16.16 results.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ov_reg      <= ov_next;
            s2_contact_reg <= !ov_next[37] && (ov_next != '0);
            s2_fgx_reg     <= s1_fgx_reg[45:16];
            s2_fgy_reg     <= s1_fgy_reg[45:16];
            s2_vn_reg      <= vnsum[50:16];
            s2_grip_reg    <= s1_up_reg[33:16];
            s2_e_reg       <= s1_ep_reg[33:16];
            s2_px_reg      <= s1_px_reg;
            s2_py_reg      <= s1_py_reg;
            s2_vx_reg      <= s1_vx_reg;
            s2_vy_reg      <= s1_vy_reg;
        end
    end

    // ---------------- stage 3 ----------------
    logic        [18:0] one_e;
    logic signed [55:0] s3_novx_reg;
    logic signed [55:0] s3_novy_reg;
    logic signed [47:0] s3_gnpx_reg;
    logic signed [47:0] s3_gnpy_reg;
    logic signed [52:0] s3_nvnx_reg;
    logic signed [52:0] s3_nvny_reg;
    logic signed [54:0] s3_sp_reg;
    logic               s3_contact_reg;
    logic signed [29:0] s3_fgx_reg;
    logic signed [29:0] s3_fgy_reg;
    logic               s3_vn_neg_reg;
    logic        [17:0] s3_grip_reg;
    logic signed [31:0] s3_px_reg;
    logic signed [31:0] s3_py_reg;
    logic signed [31:0] s3_vx_reg;
    logic signed [31:0] s3_vy_reg;

    assign one_e = 19'(s2_e_reg) + 19'(ONE_Q);

    // Push-out, gravity along normal, velocity projection and bounce products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_novx_reg    <= 56'(cfg.normal_x) * 56'(s2_ov_reg);
            s3_novy_reg    <= 56'(cfg.normal_y) * 56'(s2_ov_reg);
            s3_gnpx_reg    <= 48'(s2_fgx_reg) * 48'(cfg.normal_x);
            s3_gnpy_reg    <= 48'(s2_fgy_reg) * 48'(cfg.normal_y);
            s3_nvnx_reg    <= 53'(cfg.normal_x) * 53'(s2_vn_reg);
            s3_nvny_reg    <= 53'(cfg.normal_y) * 53'(s2_vn_reg);
            s3_sp_reg      <= 55'(s2_vn_reg) * 55'($signed({1'b0, one_e}));
            s3_contact_reg <= s2_contact_reg;
            s3_fgx_reg     <= s2_fgx_reg;
            s3_fgy_reg     <= s2_fgy_reg;
            s3_vn_neg_reg  <= s2_vn_reg[34];
            s3_grip_reg    <= s2_grip_reg;
            s3_px_reg      <= s2_px_reg;
            s3_py_reg      <= s2_py_reg;
            s3_vx_reg      <= s2_vx_reg;
            s3_vy_reg      <= s2_vy_reg;
        end
    end

    // ---------------- stage 4 ----------------
    logic signed [40:0] npx;
    logic signed [40:0] npy;
    logic signed [48:0] gnsum;
    logic signed [37:0] vpx_full;
    logic signed [37:0] vpy_full;
    logic signed [31:0] s4_opx_reg;
    logic signed [31:0] s4_opy_reg;
    logic signed [32:0] s4_gn_reg;
    logic signed [31:0] s4_vpx_reg;
    logic signed [31:0] s4_vpy_reg;
    logic signed [38:0] s4_s_reg;
    logic               s4_contact_reg;
    logic signed [29:0] s4_fgx_reg;
    logic signed [29:0] s4_fgy_reg;
    logic               s4_vn_neg_reg;
    logic        [17:0] s4_grip_reg;
    logic signed [31:0] s4_vx_reg;
    logic signed [31:0] s4_vy_reg;

    assign npx      = 41'(s3_px_reg) + 41'($signed(s3_novx_reg[55:16]));
    assign npy      = 41'(s3_py_reg) + 41'($signed(s3_novy_reg[55:16]));
    assign gnsum    = 49'(s3_gnpx_reg) + 49'(s3_gnpy_reg);
    assign vpx_full = 38'(s3_vx_reg) - 38'($signed(s3_nvnx_reg[52:16]));
    assign vpy_full = 38'(s3_vy_reg) - 38'($signed(s3_nvny_reg[52:16]));

    // Corrected position, gravity normal part and in-plane velocity.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_opx_reg     <= s3_contact_reg ? sat32(48'(npx)) : s3_px_reg;
            s4_opy_reg     <= s3_contact_reg ? sat32(48'(npy)) : s3_py_reg;
            s4_gn_reg      <= gnsum[48:16];
            s4_vpx_reg     <= sat32(48'(vpx_full));
            s4_vpy_reg     <= sat32(48'(vpy_full));
            s4_s_reg       <= s3_sp_reg[54:16];
            s4_contact_reg <= s3_contact_reg;
            s4_fgx_reg     <= s3_fgx_reg;
            s4_fgy_reg     <= s3_fgy_reg;
            s4_vn_neg_reg  <= s3_vn_neg_reg;
            s4_grip_reg    <= s3_grip_reg;
            s4_vx_reg      <= s3_vx_reg;
            s4_vy_reg      <= s3_vy_reg;
        end
    end

    // ---------------- stage 5 ----------------
    logic signed [50:0] s5_prpx_reg;
    logic signed [50:0] s5_prpy_reg;
    logic signed [56:0] s5_nspx_reg;
    logic signed [56:0] s5_nspy_reg;
    logic signed [31:0] s5_opx_reg;
    logic signed [31:0] s5_opy_reg;
    logic signed [31:0] s5_vpx_reg;
    logic signed [31:0] s5_vpy_reg;
    logic               s5_contact_reg;
    logic signed [29:0] s5_fgx_reg;
    logic signed [29:0] s5_fgy_reg;
    logic               s5_vn_neg_reg;
    logic        [17:0] s5_grip_reg;
    logic signed [31:0] s5_vx_reg;
    logic signed [31:0] s5_vy_reg;

    // Gravity projection and bounce correction products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_prpx_reg    <= 51'(cfg.normal_x) * 51'(s4_gn_reg);
            s5_prpy_reg    <= 51'(cfg.normal_y) * 51'(s4_gn_reg);
            s5_nspx_reg    <= 57'(cfg.normal_x) * 57'(s4_s_reg);
            s5_nspy_reg    <= 57'(cfg.normal_y) * 57'(s4_s_reg);
            s5_opx_reg     <= s4_opx_reg;
            s5_opy_reg     <= s4_opy_reg;
            s5_vpx_reg     <= s4_vpx_reg;
            s5_vpy_reg     <= s4_vpy_reg;
            s5_contact_reg <= s4_contact_reg;
            s5_fgx_reg     <= s4_fgx_reg;
            s5_fgy_reg     <= s4_fgy_reg;
            s5_vn_neg_reg  <= s4_vn_neg_reg;
            s5_grip_reg    <= s4_grip_reg;
            s5_vx_reg      <= s4_vx_reg;
            s5_vy_reg      <= s4_vy_reg;
        end
    end

    // ---------------- stage 6 ----------------
    logic signed [34:0] prx;
    logic signed [34:0] pry;
    logic signed [41:0] bvx;
    logic signed [41:0] bvy;
    logic signed [31:0] nvx;
    logic signed [31:0] nvy;
    side_t              s6_side_next;
    side_t              s6_side_reg;

    assign prx = s5_prpx_reg[50:16];
    assign pry = s5_prpy_reg[50:16];
    assign bvx = 42'(s5_vx_reg) - 42'($signed(s5_nspx_reg[56:16]));
    assign bvy = 42'(s5_vy_reg) - 42'($signed(s5_nspy_reg[56:16]));
    assign nvx = s5_vn_neg_reg ? sat32(48'(bvx)) : s5_vx_reg;
    assign nvy = s5_vn_neg_reg ? sat32(48'(bvy)) : s5_vy_reg;

    // Normal force, in-plane gravity and bounced velocity.
    always_comb
    begin
        s6_side_next.contact = s5_contact_reg;
        s6_side_next.opx     = s5_opx_reg;
        s6_side_next.opy     = s5_opy_reg;
        s6_side_next.ovx     = s5_contact_reg ? nvx : s5_vx_reg;
        s6_side_next.ovy     = s5_contact_reg ? nvy : s5_vy_reg;
        s6_side_next.fnx     = sat32(48'(-36'(prx)));
        s6_side_next.fny     = sat32(48'(-36'(pry)));
        s6_side_next.gpx     = sat32(48'(36'(s5_fgx_reg) - 36'(prx)));
        s6_side_next.gpy     = sat32(48'(36'(s5_fgy_reg) - 36'(pry)));
        s6_side_next.vpx     = s5_vpx_reg;
        s6_side_next.vpy     = s5_vpy_reg;
        s6_side_next.grip    = s5_grip_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s6_side_reg <= s6_side_next;
    end

    // ---------------- stage 7 ----------------
    logic signed [63:0] fx2;
    logic signed [63:0] fy2;
    logic signed [63:0] gx2;
    logic signed [63:0] gy2;
    logic signed [63:0] vx2;
    logic signed [63:0] vy2;
    front_t             s7_reg;

    assign fx2 = 64'(s6_side_reg.fnx) * 64'(s6_side_reg.fnx);
    assign fy2 = 64'(s6_side_reg.fny) * 64'(s6_side_reg.fny);
    assign gx2 = 64'(s6_side_reg.gpx) * 64'(s6_side_reg.gpx);
    assign gy2 = 64'(s6_side_reg.gpy) * 64'(s6_side_reg.gpy);
    assign vx2 = 64'(s6_side_reg.vpx) * 64'(s6_side_reg.vpx);
    assign vy2 = 64'(s6_side_reg.vpy) * 64'(s6_side_reg.vpy);

    // Squared lengths of the three vectors that need a magnitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_reg.side <= s6_side_reg;
            s7_reg.fsq  <= $unsigned(fx2) + $unsigned(fy2);
            s7_reg.gsq  <= $unsigned(gx2) + $unsigned(gy2);
            s7_reg.vsq  <= $unsigned(vx2) + $unsigned(vy2);
        end
    end

    assign res = s7_reg;

endmodule

/* sv/cpcr_isqrt.sv */
// ============================================================================
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per register stage.
// ============================================================================
module cpcr_isqrt
    import cpcr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    logic [63:0] x_in   [0:SQRT_STEPS-1];
    logic [63:0] r_in   [0:SQRT_STEPS-1];
    logic [63:0] x_next [0:SQRT_STEPS-1];
    logic [63:0] r_next [0:SQRT_STEPS-1];
    logic [63:0] x_reg  [0:SQRT_STEPS-1];
    logic [63:0] r_reg  [0:SQRT_STEPS-1];

    // Each stage tries one bit pair of the remainder.
    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] trial;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            if (k == 0)
            begin
                x_in[k] = radicand;
                r_in[k] = '0;
            end
            else
            begin
                x_in[k] = x_reg[k-1];
                r_in[k] = r_reg[k-1];
            end
            bitv  = 64'd1 << (62 - 2 * k);
            trial = r_in[k] + bitv;
            if (x_in[k] >= trial)
            begin
                x_next[k] = x_in[k] - trial;
                r_next[k] = (r_in[k] >> 1) + bitv;
            end
            else
            begin
                x_next[k] = x_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][31:0];

endmodule

/* sv/cpcr_div.sv */
// ============================================================================
// Pipelined restoring divider
// Unsigned 63-bit by 32-bit division with a 32-bit quotient, one quotient
// bit per register stage. The quotient is known to fit in 32 bits.
// ============================================================================
module cpcr_div
    import cpcr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] num,
    input  logic [31:0] den,
    output logic [31:0] quot
);

    logic [31:0] rem_in   [0:DIV_STEPS-1];
    logic [31:0] low_in   [0:DIV_STEPS-1];
    logic [31:0] den_in   [0:DIV_STEPS-1];
    logic [31:0] q_in     [0:DIV_STEPS-1];
    logic [31:0] rem_next [0:DIV_STEPS-1];
    logic [31:0] q_next   [0:DIV_STEPS-1];
    logic [31:0] rem_reg  [0:DIV_STEPS-1];
    logic [31:0] low_reg  [0:DIV_STEPS-1];
    logic [31:0] den_reg  [0:DIV_STEPS-1];
    logic [31:0] q_reg    [0:DIV_STEPS-1];

    // Shift one dividend bit into the remainder and subtract when it fits.
    always_comb
    begin
        logic [32:0] trial;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                rem_in[i] = {1'b0, num[62:32]};
                low_in[i] = num[31:0];
                den_in[i] = den;
                q_in[i]   = '0;
            end
            else
            begin
                rem_in[i] = rem_reg[i-1];
                low_in[i] = low_reg[i-1];
                den_in[i] = den_reg[i-1];
                q_in[i]   = q_reg[i-1];
            end
            trial = {rem_in[i], low_in[i][31]};
            if (trial >= {1'b0, den_in[i]})
            begin
                rem_next[i] = 32'(trial - {1'b0, den_in[i]});
                q_next[i]   = {q_in[i][30:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[31:0];
                q_next[i]   = {q_in[i][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= {low_in[i][30:0], 1'b0};
                den_reg[i] <= den_in[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign quot = q_reg[DIV_STEPS-1];

endmodule

/* sv/circle_plane_contact_response_core.sv */
// ============================================================================
// Circle/plane contact response core
// Tests a circle against a configured plane under gravity and returns the
// corrected position, the bounced velocity and the normal plus Coulomb
// friction force, all in Q16.16.
// ============================================================================
//
//  Channel    Direction  Word / fields (low bit first)
//  ---------  ---------  ------------------------------------------------------
//  s_axis     in         pos_x, pos_y, vel_x, vel_y, radius, body_mass,
//                        circle_grip, circle_bounce (208-bit word)
//  m_axis     out        new_pos_x, new_pos_y, new_vel_x, new_vel_y, force_x,
//                        force_y (192-bit word); tuser = contact
//  APB        in/out     eight plane and gravity registers at 4*i
//
//  One word is accepted per cycle unless an output word waits unaccepted.
//  The pipeline is made of the 32-stage square root and the 32-stage divider,
//  each producing one bit per stage, plus seven front stages, three middle
//  stages and the output register.
//  The whole pipeline moves together and holds while an output word waits,
//  so nothing is lost or repeated. Reset clears the valid bits and sets the
//  configuration registers to their defaults; no clearing pass is needed.
//
module circle_plane_contact_response_core
    import cpcr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, radius, body_mass, circle_grip,
    // circle_bounce, zero fill
    input  logic [207:0] s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, force_x, force_y
    output logic [191:0] m_axis_tdata,
    // contact
    output logic [0:0]   m_axis_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NSTAGES = FRONT_STAGES + SQRT_STEPS + POST_STAGES + DIV_STEPS + 1;

    localparam logic [2:0] REG_PLANE_X      = 3'd0;
    localparam logic [2:0] REG_PLANE_Y      = 3'd1;
    localparam logic [2:0] REG_NORMAL_X     = 3'd2;
    localparam logic [2:0] REG_NORMAL_Y     = 3'd3;
    localparam logic [2:0] REG_PLANE_GRIP   = 3'd4;
    localparam logic [2:0] REG_PLANE_BOUNCE = 3'd5;
    localparam logic [2:0] REG_GRAVITY_X    = 3'd6;
    localparam logic [2:0] REG_GRAVITY_Y    = 3'd7;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_DIV    = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    typedef struct packed {
        side_t      side;
        logic [1:0] mode;
        logic       negx;
        logic       negy;
    } post_t;

    // ---------------- configuration registers ----------------
    cfg_t       cfg_reg;
    logic [2:0] reg_sel;

    assign reg_sel = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane_x      <= 32'sd19660800;
            cfg_reg.plane_y      <= 32'sd52428800;
            cfg_reg.normal_x     <= 18'sd0;
            cfg_reg.normal_y     <= -18'sd65536;
            cfg_reg.plane_grip   <= 17'd65536;
            cfg_reg.plane_bounce <= 17'd58982;
            cfg_reg.gravity_x    <= 25'sd0;
            cfg_reg.gravity_y    <= 25'sd589824;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_PLANE_X:      cfg_reg.plane_x      <= pwdata;
                REG_PLANE_Y:      cfg_reg.plane_y      <= pwdata;
                REG_NORMAL_X:     cfg_reg.normal_x     <= pwdata[17:0];
                REG_NORMAL_Y:     cfg_reg.normal_y     <= pwdata[17:0];
                REG_PLANE_GRIP:   cfg_reg.plane_grip   <= pwdata[16:0];
                REG_PLANE_BOUNCE: cfg_reg.plane_bounce <= pwdata[16:0];
                REG_GRAVITY_X:    cfg_reg.gravity_x    <= pwdata[24:0];
                REG_GRAVITY_Y:    cfg_reg.gravity_y    <= pwdata[24:0];
                default:          cfg_reg.plane_x      <= cfg_reg.plane_x;
            endcase
        end
    end

    // Read back the stored bits, zero-extended.
    always_comb
    begin
        unique case (reg_sel)
            REG_PLANE_X:      prdata = cfg_reg.plane_x;
            REG_PLANE_Y:      prdata = cfg_reg.plane_y;
            REG_NORMAL_X:     prdata = {14'd0, cfg_reg.normal_x};
            REG_NORMAL_Y:     prdata = {14'd0, cfg_reg.normal_y};
            REG_PLANE_GRIP:   prdata = {15'd0, cfg_reg.plane_grip};
            REG_PLANE_BOUNCE: prdata = {15'd0, cfg_reg.plane_bounce};
            REG_GRAVITY_X:    prdata = {7'd0, cfg_reg.gravity_x};
            REG_GRAVITY_Y:    prdata = {7'd0, cfg_reg.gravity_y};
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic               en;
    logic [NSTAGES-1:0] vld_reg;

    assign en            = !vld_reg[NSTAGES-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NSTAGES-1];

    // Valid bits move in step with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGES-2:0], s_axis_tvalid};
    end

    // ---------------- front pipeline ----------------
    item_t  item;
    front_t front;

    always_comb
    begin
        item.pos_x         = s_axis_tdata[31:0];
        item.pos_y         = s_axis_tdata[63:32];
        item.vel_x         = s_axis_tdata[95:64];
        item.vel_y         = s_axis_tdata[127:96];
        item.radius        = s_axis_tdata[151:128];
        item.body_mass     = s_axis_tdata[172:152];
        item.circle_grip   = s_axis_tdata[189:173];
        item.circle_bounce = s_axis_tdata[206:190];
    end

    cpcr_front u_front (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg_reg),
        .item (item),
        .res  (front)
    );

    // ---------------- vector lengths ----------------
    logic [31:0] fn_len;
    logic [31:0] gp_len;
    logic [31:0] vp_len;

    cpcr_isqrt u_sqrt_fn (.clk(clk), .en(en), .radicand(front.fsq), .root(fn_len));
    cpcr_isqrt u_sqrt_gp (.clk(clk), .en(en), .radicand(front.gsq), .root(gp_len));
    cpcr_isqrt u_sqrt_vp (.clk(clk), .en(en), .radicand(front.vsq), .root(vp_len));

    // Side values wait for the square roots.
    side_t sq_side_reg [0:SQRT_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= front.side;
            for (int i = 1; i < SQRT_STEPS; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    // ---------------- friction magnitude ----------------
    side_t       m1_side_reg;
    logic [49:0] m1_magp_reg;
    logic [31:0] m1_gl_reg;
    logic [31:0] m1_vl_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg <= sq_side_reg[SQRT_STEPS-1];
            m1_magp_reg <= 50'(sq_side_reg[SQRT_STEPS-1].grip) * 50'(fn_len);
            m1_gl_reg   <= gp_len;
            m1_vl_reg   <= vp_len;
        end
    end

    // ---------------- friction mode select ----------------
    logic        [33:0] mag_wide;
    logic        [30:0] mag;
    logic        [1:0]  mode_next;
    logic signed [31:0] ax_next;
    logic signed [31:0] ay_next;
    logic        [31:0] den_next;

    assign mag_wide = m1_magp_reg[49:16];
    assign mag      = (mag_wide > 34'h07FFFFFFF) ? 31'h7FFFFFFF : mag_wide[30:0];

    // Sliding uses the in-plane velocity, resting uses in-plane gravity; with neither there is no friction.
    always_comb
    begin
        priority if (m1_vl_reg > 32'(VEL_EPS))
        begin
            mode_next = MODE_DIV;
            ax_next   = m1_side_reg.vpx;
            ay_next   = m1_side_reg.vpy;
            den_next  = m1_vl_reg;
        end
        else if (m1_gl_reg > 32'(GRAV_EPS))
        begin
            mode_next = (m1_gl_reg <= {1'b0, mag}) ? MODE_DIRECT : MODE_DIV;
            ax_next   = m1_side_reg.gpx;
            ay_next   = m1_side_reg.gpy;
            den_next  = m1_gl_reg;
        end
        else
        begin
            mode_next = MODE_NONE;
            ax_next   = m1_side_reg.gpx;
            ay_next   = m1_side_reg.gpy;
            den_next  = m1_gl_reg;
        end
    end

    side_t              m2_side_reg;
    logic        [1:0]  m2_mode_reg;
    logic signed [31:0] m2_ax_reg;
    logic signed [31:0] m2_ay_reg;
    logic        [31:0] m2_den_reg;
    logic        [30:0] m2_mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_side_reg <= m1_side_reg;
            m2_mode_reg <= mode_next;
            m2_ax_reg   <= ax_next;
            m2_ay_reg   <= ay_next;
            m2_den_reg  <= den_next;
            m2_mag_reg  <= mag;
        end
    end

    // ---------------- dividend products ----------------
    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [62:0] m3_numx_reg;
    logic [62:0] m3_numy_reg;
    logic [31:0] m3_den_reg;
    post_t       m3_post_reg;

    assign abs_x = m2_ax_reg[31] ? 32'(-m2_ax_reg) : 32'(m2_ax_reg);
    assign abs_y = m2_ay_reg[31] ? 32'(-m2_ay_reg) : 32'(m2_ay_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_numx_reg      <= 63'(abs_x) * 63'(m2_mag_reg);
            m3_numy_reg      <= 63'(abs_y) * 63'(m2_mag_reg);
            m3_den_reg       <= m2_den_reg;
            m3_post_reg.side <= m2_side_reg;
            m3_post_reg.mode <= m2_mode_reg;
            m3_post_reg.negx <= m2_ax_reg[31];
            m3_post_reg.negy <= m2_ay_reg[31];
        end
    end

    // ---------------- scaling division ----------------
    logic [31:0] qx;
    logic [31:0] qy;

    cpcr_div u_div_x (.clk(clk), .en(en), .num(m3_numx_reg), .den(m3_den_reg), .quot(qx));
    cpcr_div u_div_y (.clk(clk), .en(en), .num(m3_numy_reg), .den(m3_den_reg), .quot(qy));

    post_t dv_post_reg [0:DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_post_reg[0] <= m3_post_reg;
            for (int i = 1; i < DIV_STEPS; i++)
                dv_post_reg[i] <= dv_post_reg[i-1];
        end
    end

    // ---------------- final force and output word ----------------
    post_t              fin;
    logic signed [32:0] ffx;
    logic signed [32:0] ffy;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [191:0]       out_data_reg;
    logic [0:0]         out_user_reg;

    assign fin = dv_post_reg[DIV_STEPS-1];

    // Friction opposes the chosen in-plane direction.
    always_comb
    begin
        unique case (fin.mode)
            MODE_DIV:
            begin
                ffx = fin.negx ? $signed({1'b0, qx}) : -$signed({1'b0, qx});
                ffy = fin.negy ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
            end
            MODE_DIRECT:
            begin
                ffx = -33'(fin.side.gpx);
                ffy = -33'(fin.side.gpy);
            end
            default:
            begin
                ffx = '0;
                ffy = '0;
            end
        endcase
    end

    assign force_x = fin.side.contact ? sat32(48'(34'(fin.side.fnx) + 34'(ffx))) : '0;
    assign force_y = fin.side.contact ? sat32(48'(34'(fin.side.fny) + 34'(ffy))) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {force_y, force_x, fin.side.ovy, fin.side.ovx,
                             fin.side.opy, fin.side.opx};
            out_user_reg <= fin.side.contact;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

endmodule

/* dv/testbench.sv */
// ============================================================================
// Circle/plane contact response testbench
// Streams circles through the contact core under several plane and gravity
// settings and checks every result word against a predictor of the core.
// ============================================================================
module testbench
    import cpcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes of the APB map.
    localparam int REG_PLANE_X      = 0;
    localparam int REG_PLANE_Y      = 1;
    localparam int REG_NORMAL_X     = 2;
    localparam int REG_NORMAL_Y     = 3;
    localparam int REG_PLANE_GRIP   = 4;
    localparam int REG_PLANE_BOUNCE = 5;
    localparam int REG_GRAVITY_X    = 6;
    localparam int REG_GRAVITY_Y    = 7;

    localparam int PIPE_LATENCY = 75;
    localparam int STALL_LIMIT  = 4000;
    localparam int DIAG         = 46341;

    typedef struct packed {
        logic               contact;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } response_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    circle_plane_contact_response_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a period of 8 ns.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    cfg_t      plane_cfg;
    item_t     pending_circles[$];
    response_t expected_responses[$];
    logic      word_taken;
    logic      no_idle;
    int        fail_count;
    int        stall_cycles;

    // ------------------------------------------------------------------------
    // Predictor of the core
    // ------------------------------------------------------------------------
    function automatic longint fl16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Floor square root of the sum of squares of two 32-bit components.
    function automatic longint vec_len(longint x, longint y);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = 64'(x * x) + 64'(y * y);
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic response_t predict_contact(item_t c);
        response_t o;
        longint px, py, vx, vy, r, m, cg, cb;
        longint qx, qy, nx, ny, pg, pb, gx, gy;
        longint d, ov, fgx, fgy, gn, prx, pry, fnx, fny, gpx, gpy, gplen;
        longint u, mag, vn, vpx, vpy, vplen, nvx, nvy, ffx, ffy, e, s;
        px = c.pos_x;  py = c.pos_y;  vx = c.vel_x;  vy = c.vel_y;
        r  = c.radius; m = c.body_mass; cg = c.circle_grip; cb = c.circle_bounce;
        qx = plane_cfg.plane_x;    qy = plane_cfg.plane_y;
        nx = plane_cfg.normal_x;   ny = plane_cfg.normal_y;
        pg = plane_cfg.plane_grip; pb = plane_cfg.plane_bounce;
        gx = plane_cfg.gravity_x;  gy = plane_cfg.gravity_y;
        d  = fl16((px - qx) * nx + (py - qy) * ny);
        ov = r - d;
        if (ov <= 0)
        begin
            o.contact   = 1'b0;
            o.new_pos_x = c.pos_x;
            o.new_pos_y = c.pos_y;
            o.new_vel_x = c.vel_x;
            o.new_vel_y = c.vel_y;
            o.force_x   = '0;
            o.force_y   = '0;
            return o;
        end
        fgx   = fl16(gx * m);
        fgy   = fl16(gy * m);
        gn    = fl16(fgx * nx + fgy * ny);
        prx   = fl16(nx * gn);
        pry   = fl16(ny * gn);
        fnx   = clip32(-prx);
        fny   = clip32(-pry);
        gpx   = clip32(fgx - prx);
        gpy   = clip32(fgy - pry);
        gplen = vec_len(gpx, gpy);
        u     = fl16(cg * pg);
        mag   = clip32(fl16(u * vec_len(fnx, fny)));
        vn    = fl16(vx * nx + vy * ny);
        vpx   = clip32(vx - fl16(nx * vn));
        vpy   = clip32(vy - fl16(ny * vn));
        vplen = vec_len(vpx, vpy);
        nvx   = vx;
        nvy   = vy;
        ffx   = 0;
        ffy   = 0;
        // A closing circle has its normal velocity reflected with restitution.
        if (vn < 0)
        begin
            e   = fl16(cb * pb);
            s   = fl16(vn * (ONE_Q + e));
            nvx = vx - fl16(nx * s);
            nvy = vy - fl16(ny * s);
        end
        // Kinetic friction while sliding, else static friction against gravity.
        if (vplen > VEL_EPS)
        begin
            ffx = -((vpx * mag) / vplen);
            ffy = -((vpy * mag) / vplen);
        end
        else if (gplen > GRAV_EPS)
        begin
            if (gplen <= mag)
            begin
                ffx = -gpx;
                ffy = -gpy;
            end
            else
            begin
                ffx = -((gpx * mag) / gplen);
                ffy = -((gpy * mag) / gplen);
            end
        end
        o.contact   = 1'b1;
        o.new_pos_x = 32'(clip32(px + fl16(nx * ov)));
        o.new_pos_y = 32'(clip32(py + fl16(ny * ov)));
        o.new_vel_x = 32'(clip32(nvx));
        o.new_vel_y = 32'(clip32(nvy));
        o.force_x   = 32'(clip32(fnx + ffx));
        o.force_y   = 32'(clip32(fny + ffy));
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stream driver: presents the oldest pending circle at the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || word_taken))
        begin
            if (pending_circles.size() > 0 && (no_idle || $urandom_range(99) >= 8))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, pending_circles[0].circle_bounce,
                                  pending_circles[0].circle_grip,
                                  pending_circles[0].body_mass,
                                  pending_circles[0].radius,
                                  pending_circles[0].vel_y, pending_circles[0].vel_x,
                                  pending_circles[0].pos_y, pending_circles[0].pos_x};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        if (rst_n)
            m_axis_tready <= no_idle || ($urandom_range(99) >= 8);
    end

    // Input side: an accepted word turns into an expected response.
    always @(posedge clk)
    begin
        word_taken = s_axis_tvalid && s_axis_tready;
        if (word_taken)
            expected_responses.insert(expected_responses.size(),
                                      predict_contact(pending_circles.pop_front()));
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result word against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        response_t want;
        response_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32],
                   m_axis_tdata[95:64], m_axis_tdata[127:96],
                   m_axis_tdata[159:128], m_axis_tdata[191:160]};
            if (expected_responses.size() == 0)
            begin
                $error("result word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = expected_responses.pop_front();
                if (got.contact !== want.contact)
                begin
                    $error("contact: expected %0d, got %0d", want.contact, got.contact);
                    fail_count++;
                end
                if (got.new_pos_x !== want.new_pos_x)
                begin
                    $error("new_pos_x: expected %0d, got %0d", want.new_pos_x,
                           got.new_pos_x);
                    fail_count++;
                end
                if (got.new_pos_y !== want.new_pos_y)
                begin
                    $error("new_pos_y: expected %0d, got %0d", want.new_pos_y,
                           got.new_pos_y);
                    fail_count++;
                end
                if (got.new_vel_x !== want.new_vel_x)
                begin
                    $error("new_vel_x: expected %0d, got %0d", want.new_vel_x,
                           got.new_vel_x);
                    fail_count++;
                end
                if (got.new_vel_y !== want.new_vel_y)
                begin
                    $error("new_vel_y: expected %0d, got %0d", want.new_vel_y,
                           got.new_vel_y);
                    fail_count++;
                end
                if (got.force_x !== want.force_x)
                begin
                    $error("force_x: expected %0d, got %0d", want.force_x, got.force_x);
                    fail_count++;
                end
                if (got.force_y !== want.force_y)
                begin
                    $error("force_y: expected %0d, got %0d", want.force_y, got.force_y);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles without progress while work is outstanding.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_circles.size() == 0 && expected_responses.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register access and circle generation
    // ------------------------------------------------------------------------
    task automatic apb_write(input int idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PLANE_X:      plane_cfg.plane_x      = value;
            REG_PLANE_Y:      plane_cfg.plane_y      = value;
            REG_NORMAL_X:     plane_cfg.normal_x     = value[17:0];
            REG_NORMAL_Y:     plane_cfg.normal_y     = value[17:0];
            REG_PLANE_GRIP:   plane_cfg.plane_grip   = value[16:0];
            REG_PLANE_BOUNCE: plane_cfg.plane_bounce = value[16:0];
            REG_GRAVITY_X:    plane_cfg.gravity_x    = value[24:0];
            default:          plane_cfg.gravity_y    = value[24:0];
        endcase
    endtask

    // Writes one full plane setting; the normal comes from a set of directions or is random.
    task automatic set_plane(input int dir, input logic [31:0] qx, input logic [31:0] qy,
                             input logic [31:0] grip, input logic [31:0] bounce,
                             input logic [31:0] gx, input logic [31:0] gy);
        int nx;
        int ny;
        case (dir)
            0:       begin nx = 0;      ny = -ONE_Q; end
            1:       begin nx = ONE_Q;  ny = 0;      end
            2:       begin nx = 0;      ny = ONE_Q;  end
            3:       begin nx = -ONE_Q; ny = 0;      end
            4:       begin nx = DIAG;   ny = -DIAG;  end
            5:       begin nx = -DIAG;  ny = DIAG;   end
            default: begin nx = $urandom; ny = $urandom; end
        endcase
        apb_write(REG_PLANE_X, qx);
        apb_write(REG_PLANE_Y, qy);
        apb_write(REG_NORMAL_X, nx);
        apb_write(REG_NORMAL_Y, ny);
        apb_write(REG_PLANE_GRIP, grip);
        apb_write(REG_PLANE_BOUNCE, bounce);
        apb_write(REG_GRAVITY_X, gx);
        apb_write(REG_GRAVITY_Y, gy);
    endtask

    function automatic int small_signed(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // A random circle: mostly near the plane point so that contacts are common.
    function automatic item_t random_circle();
        item_t c;
        int mode;
        mode            = $urandom_range(9);
        c.radius        = 24'($urandom_range(32'h3F_FFFF));
        c.pos_x         = plane_cfg.plane_x + small_signed(32'h40_0000);
        c.pos_y         = plane_cfg.plane_y + small_signed(32'h40_0000);
        c.body_mass     = 21'($urandom_range(1310720, 6554));
        c.circle_grip   = 17'($urandom_range(ONE_Q));
        c.circle_bounce = 17'($urandom_range(ONE_Q));
        case ($urandom_range(3))
            0:       begin c.vel_x = 0; c.vel_y = 0; end
            1:       begin c.vel_x = small_signed(60); c.vel_y = small_signed(60); end
            2:       begin c.vel_x = small_signed(32'h10_0000);
                           c.vel_y = small_signed(32'h10_0000); end
            default: begin c.vel_x = $urandom; c.vel_y = $urandom; end
        endcase
        if (mode >= 8)
            c = 208'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom});
        else if (mode == 7)
        begin
            c.radius        = 24'($urandom);
            c.body_mass     = 21'($urandom);
            c.circle_grip   = 17'($urandom);
            c.circle_bounce = 17'($urandom);
        end
        return c;
    endfunction

    // Edge cases, mostly at the plane point, one per index.
    function automatic item_t edge_circle(int k);
        item_t c;
        c.pos_x         = plane_cfg.plane_x;
        c.pos_y         = plane_cfg.plane_y;
        c.vel_x         = 0;
        c.vel_y         = 0;
        c.radius        = 24'd655360;
        c.body_mass     = 21'd65536;
        c.circle_grip   = 17'd32768;
        c.circle_bounce = 17'd32768;
        case (k)
            0:  c.radius = '0;
            1:  c.radius = 24'hFF_FFFF;
            2:  begin c.vel_x = 32'sd50; c.vel_y = -32'sd30; end
            3:  c.vel_y = 32'sd655360;
            4:  c.vel_y = -32'sd655360;
            5:  c.vel_x = 32'sd655360;
            6:  begin c.vel_x = 32'sh7FFF_FFFF; c.vel_y = 32'sh8000_0000; end
            7:  begin c.vel_x = 32'sh8000_0000; c.vel_y = 32'sh7FFF_FFFF; end
            8:  c.pos_x = 32'sh7FFF_FFFF;
            9:  c.pos_y = 32'sh8000_0000;
            10: begin c.pos_x = 32'sh8000_0000; c.pos_y = 32'sh7FFF_FFFF; end
            11: c.body_mass = 21'd6554;
            12: c.body_mass = 21'd1310720;
            13: c.body_mass = 21'h1F_FFFF;
            14: begin c.circle_grip = '0; c.circle_bounce = '0; c.vel_y = -32'sd65536; end
            15: begin c.circle_grip = 17'(ONE_Q); c.circle_bounce = 17'(ONE_Q);
                      c.vel_y = -32'sd65536; end
            16: begin c.circle_grip = 17'h1_FFFF; c.circle_bounce = 17'h1_FFFF;
                      c.vel_y = 32'sd65536; end
            17: c.pos_y = plane_cfg.plane_y - 32'sd10_000_000;
            default: c.pos_y = plane_cfg.plane_y + 32'sd10_000_000;
        endcase
        return c;
    endfunction

    // Waits until every circle has been sent and every response has come.
    task automatic drain();
        while (pending_circles.size() > 0 || expected_responses.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        word_taken    = 1'b0;
        no_idle       = 1'b0;
        fail_count    = 0;
        stall_cycles  = 0;
        plane_cfg     = {32'sd19660800, 32'sd52428800, 18'sd0, -18'sd65536,
                         17'd65536, 17'd58982, 25'sd0, 25'sd589824};
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases under the reset plane.
        for (int k = 0; k < 19; k++)
            pending_circles.insert(pending_circles.size(), edge_circle(k));
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_plane(0, 32'sd19660800, 32'sd52428800, ONE_Q, 58982, 0, 589824);
                1: set_plane(1, 0, 0, 0, 0, 32'(-11796480), 32'(11796480));
                2: set_plane(2, 32'sh7FF0_0000, 32'sh8010_0000, ONE_Q, ONE_Q,
                             32'(11796480), 32'(-11796480));
                3: set_plane(3, $urandom, $urandom, $urandom_range(ONE_Q),
                             $urandom_range(ONE_Q), 32'(small_signed(11796480)),
                             32'(small_signed(11796480)));
                4: set_plane(4, 32'sd1000000, -32'sd1000000, 32768, 32768, 0, 0);
                5: set_plane(5, 0, 0, ONE_Q, ONE_Q, 3, 2);
                default: set_plane(6, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom);
            endcase
            // One phase runs with no idling on either side.
            no_idle = (phase == 2);
            for (int k = 0; k < 6; k++)
                pending_circles.insert(pending_circles.size(),
                                       edge_circle($urandom_range(18)));
            for (int k = 0; k < 235; k++)
            begin
                pending_circles.insert(pending_circles.size(), random_circle());
                // Once per phase, hold off the sender until the pipe has emptied.
                if (k == 120)
                begin
                    while (pending_circles.size() > 0 || expected_responses.size() > 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
